@@ design/iir_32nd_order_direct_form_assert.svh @@
// Assertion macros for the direct form I IIR filter checker.
`ifndef IIR_32ND_ORDER_DIRECT_FORM_ASSERT_SVH
`define IIR_32ND_ORDER_DIRECT_FORM_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define IIR32DF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define IIR32DF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/iir32df_pkg.sv @@
// Shared types, constants and microcode table of the direct form I IIR filter.
package iir32df_pkg;

    // Fixed formats of the item fields
    localparam int TAPS_DEFAULT = 32;
    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 32;
    localparam int GAIN_BITS    = 24;
    localparam int IDX_BITS     = 5;
    localparam int CMD_BITS     = 2;
    localparam int ACC_BITS     = 64;
    localparam int MUL_BITS     = COEF_BITS;

    localparam int COEF_FRAC    = COEF_BITS - 8;
    localparam int SAMPLE_FRAC  = SAMPLE_BITS - 1;
    localparam int GAIN_FRAC    = 16;
    localparam int FF_SHIFT     = COEF_FRAC - SAMPLE_FRAC;
    localparam int OUT_SHIFT    = COEF_FRAC + GAIN_FRAC - SAMPLE_FRAC;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(65536);

    // Command codes of an input item
    localparam logic [CMD_BITS-1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_LOAD_FF = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_LOAD_FB = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 2'd3;

    // Multiplier operation, carried down the read/multiply/accumulate pipe
    typedef enum logic [2:0] {
        MOP_NONE = 3'd0,
        MOP_FF0  = 3'd1,
        MOP_FF   = 3'd2,
        MOP_FB   = 3'd3,
        MOP_GAIN = 3'd4
    } t_mop;

    // Sequencer branch kinds
    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_GOTO     = 3'd1,
        J_LOOP     = 3'd2,
        J_DISPATCH = 3'd3,
        J_WAIT     = 3'd4
    } t_jmp;

    typedef logic [3:0] t_upc;

    // Microprogram step addresses
    localparam t_upc U_IDLE  = 4'd0;
    localparam t_upc U_X0    = 4'd1;
    localparam t_upc U_FF    = 4'd2;
    localparam t_upc U_FB    = 4'd3;
    localparam t_upc U_D1    = 4'd4;
    localparam t_upc U_D2    = 4'd5;
    localparam t_upc U_SAT   = 4'd6;
    localparam t_upc U_GAIN  = 4'd7;
    localparam t_upc U_GWAIT = 4'd8;
    localparam t_upc U_OUT   = 4'd9;

    // One control word
    typedef struct packed {
        logic  in_ready;
        t_mop  mop;
        logic  x_write;
        logic  tap_adv;
        logic  y_sat;
        logic  out_load;
        t_jmp  jmp;
        t_upc  target;
    } t_uword;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic last_tap;
        logic out_free;
    } t_stat;

    localparam t_uword UW_NOP = '{
        in_ready: 1'b0, mop: MOP_NONE, x_write: 1'b0, tap_adv: 1'b0,
        y_sat: 1'b0, out_load: 1'b0, jmp: J_NEXT, target: U_IDLE
    };

    // Control store
    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        w = UW_NOP;
        case (upc)
            U_IDLE: begin
                w.in_ready = 1'b1;
                w.jmp      = J_DISPATCH;
                w.target   = U_X0;
            end
            U_X0: begin
                w.mop     = MOP_FF0;
                w.x_write = 1'b1;
            end
            U_FF: begin
                w.mop = MOP_FF;
            end
            U_FB: begin
                w.mop     = MOP_FB;
                w.tap_adv = 1'b1;
                w.jmp     = J_LOOP;
                w.target  = U_FF;
            end
            U_D1:    w.jmp = J_NEXT;
            U_D2:    w.jmp = J_NEXT;
            U_SAT:   w.y_sat = 1'b1;
            U_GAIN:  w.mop = MOP_GAIN;
            U_GWAIT: w.jmp = J_NEXT;
            U_OUT: begin
                w.out_load = 1'b1;
                w.jmp      = J_WAIT;
                w.target   = U_IDLE;
            end
            default: begin
                w.jmp    = J_GOTO;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ design/iir32df_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module iir32df_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/iir32df_seq.sv @@
// Microcode sequencer: step counter, control store lookup and branch logic.
module iir32df_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic [iir32df_pkg::CMD_BITS-1:0] i_cmd,
    input  iir32df_pkg::t_stat               i_stat,
    output iir32df_pkg::t_uword              o_ctl
);

    iir32df_pkg::t_upc   r_upc;
    iir32df_pkg::t_upc   n_upc;
    iir32df_pkg::t_uword word;

    assign word  = iir32df_pkg::ucode(r_upc);
    assign o_ctl = word;

    // Pick the next step
    always_comb begin
        case (word.jmp)
            iir32df_pkg::J_NEXT: n_upc = r_upc + 4'd1;
            iir32df_pkg::J_GOTO: n_upc = word.target;
            iir32df_pkg::J_LOOP: n_upc = i_stat.last_tap ? r_upc + 4'd1 : word.target;
            iir32df_pkg::J_DISPATCH: begin
                n_upc = (i_in_valid && i_cmd == iir32df_pkg::CMD_SAMPLE) ? word.target : r_upc;
            end
            iir32df_pkg::J_WAIT: n_upc = i_stat.out_free ? word.target : r_upc;
            default: n_upc = iir32df_pkg::U_IDLE;
        endcase
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= iir32df_pkg::U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

@@ design/iir32df_dp.sv @@
// Datapath: history and coefficient stores, shared multiplier, accumulator, output register.
module iir32df_dp #(
    parameter int TAPS = iir32df_pkg::TAPS_DEFAULT
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  iir32df_pkg::t_uword                        i_ctl,
    output iir32df_pkg::t_stat                         o_stat,
    input  logic                                       i_in_valid,
    input  logic [iir32df_pkg::CMD_BITS-1:0]           i_cmd,
    input  logic signed [iir32df_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic [iir32df_pkg::IDX_BITS-1:0]           i_coef_index,
    input  logic signed [iir32df_pkg::COEF_BITS-1:0]   i_coef_value,
    input  logic                                       i_cfg_we,
    input  logic [iir32df_pkg::GAIN_BITS-1:0]          i_cfg_wdata,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic signed [iir32df_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                       o_clipped
);

    localparam int AW = $clog2(TAPS);
    localparam int SB = iir32df_pkg::SAMPLE_BITS;
    localparam int CB = iir32df_pkg::COEF_BITS;
    localparam int MB = iir32df_pkg::MUL_BITS;
    localparam int AB = iir32df_pkg::ACC_BITS;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    // Item acceptance and decode
    logic accept;
    logic coef_ok;
    logic [AW-1:0] coef_addr;
    logic we_ff;
    logic we_fb;

    assign accept    = i_in_valid && i_ctl.in_ready;
    assign coef_ok   = int'(i_coef_index) < TAPS;
    assign coef_addr = AW'(i_coef_index);
    assign we_ff     = accept && i_cmd == iir32df_pkg::CMD_LOAD_FF && coef_ok;
    assign we_fb     = accept && i_cmd == iir32df_pkg::CMD_LOAD_FB && coef_ok;

    // Control and address registers
    logic [AW-1:0] r_slot;
    logic [AW-1:0] r_tap;
    logic [AW-1:0] r_ptr;
    logic [TAPS-1:0] r_xv, r_yv, r_fv, r_bv;
    iir32df_pkg::t_mop r_mop1, r_mop2;
    logic r_out_valid;

    // Payload registers
    logic signed [SB-1:0] r_x0;
    logic [iir32df_pkg::GAIN_BITS-1:0] r_gain;
    logic [CB-1:0] r_y;
    logic r_hit;
    logic [AB-1:0] r_prod;
    logic [AB-1:0] r_acc;
    logic r_fok, r_bok, r_xok, r_yok;
    logic signed [SB-1:0] r_out_sample;
    logic r_out_clip;

    // Store read data and addresses
    logic [CB-1:0] f_q, b_q, y_q;
    logic [SB-1:0] x_q;
    logic [AW-1:0] f_raddr;
    logic [AW-1:0] slot_dec;
    logic [AW-1:0] ptr_dec;

    assign f_raddr  = (i_ctl.mop == iir32df_pkg::MOP_FF0) ? '0 : r_tap;
    assign slot_dec = (r_slot == '0) ? LAST : r_slot - AW'(1);
    assign ptr_dec  = (r_ptr == '0) ? LAST : r_ptr - AW'(1);

    // Feedback saturation
    logic signed [AB-1:0] acc_sh;
    logic y_ov;
    logic [CB-1:0] y_val;

    assign acc_sh = $signed(r_acc) >>> iir32df_pkg::COEF_FRAC;
    assign y_ov   = !((&acc_sh[AB-1:CB-1]) || !(|acc_sh[AB-1:CB-1]));
    assign y_val  = y_ov ? (acc_sh[AB-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}})
                         : acc_sh[CB-1:0];

    // Output saturation
    logic signed [AB-1:0] g_sh;
    logic g_ov;
    logic [SB-1:0] q_val;
    logic out_free;
    logic out_load;

    assign g_sh  = $signed(r_prod) >>> iir32df_pkg::OUT_SHIFT;
    assign g_ov  = !((&g_sh[AB-1:SB-1]) || !(|g_sh[AB-1:SB-1]));
    assign q_val = g_ov ? (g_sh[AB-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}})
                        : g_sh[SB-1:0];

    assign out_free        = !r_out_valid || i_out_ready;
    assign out_load        = i_ctl.out_load && out_free;
    assign o_stat.out_free = out_free;
    assign o_stat.last_tap = (r_tap == LAST);

    // Stores
    iir32df_ram #(.WIDTH(CB), .DEPTH(TAPS)) u_fcoef (
        .i_clk   (i_clk),
        .i_we    (we_ff),
        .i_waddr (coef_addr),
        .i_wdata (i_coef_value),
        .i_raddr (f_raddr),
        .o_rdata (f_q)
    );

    iir32df_ram #(.WIDTH(CB), .DEPTH(TAPS)) u_bcoef (
        .i_clk   (i_clk),
        .i_we    (we_fb),
        .i_waddr (coef_addr),
        .i_wdata (i_coef_value),
        .i_raddr (r_tap),
        .o_rdata (b_q)
    );

    iir32df_ram #(.WIDTH(SB), .DEPTH(TAPS)) u_xhist (
        .i_clk   (i_clk),
        .i_we    (i_ctl.x_write),
        .i_waddr (r_slot),
        .i_wdata (r_x0),
        .i_raddr (r_ptr),
        .o_rdata (x_q)
    );

    iir32df_ram #(.WIDTH(CB), .DEPTH(TAPS)) u_yhist (
        .i_clk   (i_clk),
        .i_we    (i_ctl.y_sat),
        .i_waddr (r_slot),
        .i_wdata (y_val),
        .i_raddr (r_ptr),
        .o_rdata (y_q)
    );

    // Multiplier operand select; entries never written read as zero
    logic signed [MB-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [2*MB-1:0] mul_p;

    always_comb begin
        case (r_mop1)
            iir32df_pkg::MOP_FF0: begin
                mul_a = r_fok ? $signed(f_q) : '0;
                mul_b = MB'(r_x0);
            end
            iir32df_pkg::MOP_FF: begin
                mul_a = r_fok ? $signed(f_q) : '0;
                mul_b = r_xok ? MB'($signed(x_q)) : '0;
            end
            iir32df_pkg::MOP_FB: begin
                mul_a = r_bok ? $signed(b_q) : '0;
                mul_b = r_yok ? $signed(y_q) : '0;
            end
            iir32df_pkg::MOP_GAIN: begin
                mul_a = $signed(r_y);
                mul_b = MB'($signed({1'b0, r_gain}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Control state: pipe stages, pointers, valid flags, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mop1      <= iir32df_pkg::MOP_NONE;
            r_mop2      <= iir32df_pkg::MOP_NONE;
            r_slot      <= '0;
            r_tap       <= '0;
            r_ptr       <= '0;
            r_xv        <= '0;
            r_yv        <= '0;
            r_fv        <= '0;
            r_bv        <= '0;
            r_out_valid <= 1'b0;
            r_gain      <= iir32df_pkg::GAIN_RESET;
        end else begin
            r_mop1 <= i_ctl.mop;
            r_mop2 <= r_mop1;
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            if (we_ff) begin
                r_fv[coef_addr] <= 1'b1;
            end
            if (we_fb) begin
                r_bv[coef_addr] <= 1'b1;
            end
            if (accept && i_cmd == iir32df_pkg::CMD_CLEAR) begin
                r_xv <= '0;
                r_yv <= '0;
            end
            // start the tap walk one slot behind the newest sample
            if (i_ctl.x_write) begin
                r_xv[r_slot] <= 1'b1;
                r_tap        <= AW'(1);
                r_ptr        <= slot_dec;
            end
            if (i_ctl.tap_adv) begin
                r_tap <= r_tap + AW'(1);
                r_ptr <= ptr_dec;
            end
            if (i_ctl.y_sat) begin
                r_yv[r_slot] <= 1'b1;
                r_slot       <= (r_slot == LAST) ? '0 : r_slot + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: sample capture, read flags, product, accumulator, results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x0 <= i_sample_in;
        end
        r_fok <= r_fv[f_raddr];
        r_bok <= r_bv[r_tap];
        r_xok <= r_xv[r_ptr];
        r_yok <= r_yv[r_ptr];
        if (r_mop1 != iir32df_pkg::MOP_NONE) begin
            r_prod <= AB'(mul_p);
        end
        case (r_mop2)
            iir32df_pkg::MOP_FF0: r_acc <= r_prod << iir32df_pkg::FF_SHIFT;
            iir32df_pkg::MOP_FF:  r_acc <= r_acc + (r_prod << iir32df_pkg::FF_SHIFT);
            iir32df_pkg::MOP_FB:  r_acc <= r_acc + r_prod;
            default:              r_acc <= r_acc;
        endcase
        if (i_ctl.y_sat) begin
            r_y   <= y_val;
            r_hit <= y_ov;
        end
        if (out_load) begin
            r_out_sample <= $signed(q_val);
            r_out_clip   <= r_hit || g_ov;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_clipped    = r_out_clip;

endmodule

@@ design/iir_32nd_order_direct_form.sv @@
// Top level of the direct form I IIR filter: sequencer and datapath.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   in       | i_in_valid / o_in_ready    | i_cmd, i_sample_in, i_coef_index, i_coef_value
//   out      | o_out_valid / i_out_ready  | o_sample_out, o_clipped
//   config   | i_cfg_we (no wait)         | i_cfg_wdata (output gain, Q8.16)
//
// A sample item closes the input until its run ends: the single shared
// multiplier forms one product per clock over the feed-forward and feedback
// taps, then the gain product. Load and clear items leave the sequencer idle.
// Reset is synchronous; per-entry valid flags make all stores read as zero
// right after reset, and the history stores after a clear, with no sweep.
// A full output register stalls the sequencer on its last step only.
module iir_32nd_order_direct_form #(
    parameter int TAPS = iir32df_pkg::TAPS_DEFAULT
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic [iir32df_pkg::CMD_BITS-1:0]           i_cmd,
    input  logic signed [iir32df_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic [iir32df_pkg::IDX_BITS-1:0]           i_coef_index,
    input  logic signed [iir32df_pkg::COEF_BITS-1:0]   i_coef_value,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic signed [iir32df_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                       o_clipped,
    input  logic                                       i_cfg_we,
    input  logic [iir32df_pkg::GAIN_BITS-1:0]          i_cfg_wdata
);

    iir32df_pkg::t_uword ctl;
    iir32df_pkg::t_stat  stat;

    assign o_in_ready = ctl.in_ready;

    iir32df_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    iir32df_dp #(.TAPS(TAPS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_stat       (stat),
        .i_in_valid   (i_in_valid),
        .i_cmd        (i_cmd),
        .i_sample_in  (i_sample_in),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

endmodule

@@ design/iir32df_chk.sv @@
// Port-level checker for the direct form I IIR filter, bound to the top level.
`include "iir_32nd_order_direct_form_assert.svh"

module iir32df_chk (
    input logic                                       i_clk,
    input logic                                       i_rst_n,
    input logic                                       i_in_valid,
    input logic                                       o_in_ready,
    input logic [iir32df_pkg::CMD_BITS-1:0]           i_cmd,
    input logic                                       o_out_valid,
    input logic                                       i_out_ready,
    input logic signed [iir32df_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input logic                                       o_clipped
);

    // A stalled result item holds its value
    `IIR32DF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_sample_out) && $stable(o_clipped),
        "result item changed while stalled")

    // A sample item starts the filter run, so the input side closes
    `IIR32DF_ASSERT_NEXT(a_sample_busy,
        i_in_valid && o_in_ready && i_cmd == iir32df_pkg::CMD_SAMPLE,
        !o_in_ready, "input still open after a sample item")

    // Load and clear items leave the input side open
    `IIR32DF_ASSERT_NEXT(a_ctrl_quick,
        i_in_valid && o_in_ready && i_cmd != iir32df_pkg::CMD_SAMPLE,
        o_in_ready, "input closed after a load or clear item")

    // A new result appears exactly as the filter returns to waiting
    `IIR32DF_ASSERT_NOW(a_out_at_end, $rose(o_out_valid), o_in_ready,
        "result shown while the filter run is still going")

endmodule

bind iir_32nd_order_direct_form iir32df_chk u_chk (.*);

@@ verif/tb.sv @@
// Testbench of the direct form I IIR filter: directed and random items checked on a local model.
`timescale 1ns / 100ps

module tb;
    import iir32df_pkg::*;

    localparam int NTAPS        = TAPS_DEFAULT;
    localparam int BUSY_CYCLES  = 2 * NTAPS + 6;
    localparam int QUIET_CYCLES = BUSY_CYCLES + 10;

    localparam logic signed [63:0] Y_MAX = (64'sd1 <<< (COEF_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] Y_MIN = -Y_MAX - 64'sd1;
    localparam logic signed [63:0] S_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] S_MIN = -S_MAX - 64'sd1;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [COEF_BITS-1:0]   CF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [COEF_BITS-1:0]   CF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic signed [COEF_BITS-1:0]   CF_ONE  = COEF_BITS'(1) <<< COEF_FRAC;
    localparam logic [IDX_BITS-1:0]           LAST_TAP = IDX_BITS'(NTAPS - 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          clipped;
    } t_filt_out;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_ready;
    logic [CMD_BITS-1:0]           i_cmd        = CMD_SAMPLE;
    logic signed [SAMPLE_BITS-1:0] i_sample_in  = '0;
    logic [IDX_BITS-1:0]           i_coef_index = '0;
    logic signed [COEF_BITS-1:0]   i_coef_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready  = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic                          o_clipped;
    logic                          i_cfg_we     = 1'b0;
    logic [GAIN_BITS-1:0]          i_cfg_wdata  = '0;

    // Filter model state
    logic signed [SAMPLE_BITS-1:0] x_hist [NTAPS];
    logic signed [COEF_BITS-1:0]   y_hist [NTAPS];
    logic signed [COEF_BITS-1:0]   ff_coef [NTAPS];
    logic signed [COEF_BITS-1:0]   fb_coef [NTAPS];
    logic [IDX_BITS-1:0]           slot;
    logic [GAIN_BITS-1:0]          gain_q816;
    t_filt_out                     filtered_q [$];

    int err_count    = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;

    iir_32nd_order_direct_form #(.TAPS(NTAPS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_sample_in  (i_sample_in),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the output side at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    // Compare each accepted result with the oldest expected one
    always @(posedge i_clk) begin
        t_filt_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("unexpected result item", 32'(o_sample_out), '0);
            end else begin
                want = filtered_q.pop_front();
                if (o_sample_out !== want.smp)
                    report_mismatch("sample_out", 32'(o_sample_out), 32'(want.smp));
                if (o_clipped !== want.clipped)
                    report_mismatch("clipped", 32'(o_clipped), 32'(want.clipped));
            end
        end
    end

    // Advance the filter model by one accepted item
    function automatic void filter_model(input logic [CMD_BITS-1:0] cmd,
                                         input logic signed [SAMPLE_BITS-1:0] smp,
                                         input logic [IDX_BITS-1:0] idx,
                                         input logic signed [COEF_BITS-1:0] val);
        logic signed [63:0]  acc;
        logic signed [63:0]  ca;
        logic signed [63:0]  da;
        logic signed [63:0]  y_wide;
        logic signed [63:0]  q;
        logic [IDX_BITS-1:0] z;
        logic                hit;
        t_filt_out           r;
        int                  k;
        hit = 1'b0;
        case (cmd)
            CMD_LOAD_FF: ff_coef[idx] = val;
            CMD_LOAD_FB: fb_coef[idx] = val;
            CMD_CLEAR: begin
                for (k = 0; k < NTAPS; k++) begin
                    x_hist[k] = '0;
                    y_hist[k] = '0;
                end
            end
            default: begin
                x_hist[slot] = smp;
                ca = ff_coef[0];
                da = smp;
                acc = (ca * da) <<< FF_SHIFT;
                for (k = 1; k < NTAPS; k++) begin
                    z = slot - IDX_BITS'(k);
                    ca = ff_coef[k];
                    da = x_hist[z];
                    acc += (ca * da) <<< FF_SHIFT;
                    ca = fb_coef[k];
                    da = y_hist[z];
                    acc += ca * da;
                end
                // saturate the feedback value to Q8.24
                y_wide = acc >>> COEF_FRAC;
                if (y_wide > Y_MAX) begin
                    hit = 1'b1;
                    y_wide = Y_MAX;
                end else if (y_wide < Y_MIN) begin
                    hit = 1'b1;
                    y_wide = Y_MIN;
                end
                y_hist[slot] = y_wide[COEF_BITS-1:0];
                slot = slot + 1'b1;
                // apply gain and saturate to the sample width
                ca = y_wide;
                da = {{(64-GAIN_BITS){1'b0}}, gain_q816};
                q = (ca * da) >>> OUT_SHIFT;
                if (q > S_MAX) begin
                    hit = 1'b1;
                    q = S_MAX;
                end else if (q < S_MIN) begin
                    hit = 1'b1;
                    q = S_MIN;
                end
                r.smp = q[SAMPLE_BITS-1:0];
                r.clipped = hit;
                filtered_q.push_back(r);
            end
        endcase
    endfunction

    // Present one item, hold it until accepted, then update the model
    task automatic send_item(input logic [CMD_BITS-1:0] cmd,
                             input logic signed [SAMPLE_BITS-1:0] smp,
                             input logic [IDX_BITS-1:0] idx,
                             input logic signed [COEF_BITS-1:0] val);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_sample_in  <= smp;
        i_coef_index <= idx;
        i_coef_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        filter_model(cmd, smp, idx, val);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        send_item(CMD_SAMPLE, smp, IDX_BITS'($urandom), COEF_BITS'($urandom));
    endtask

    task automatic send_load(input logic [CMD_BITS-1:0] cmd, input logic [IDX_BITS-1:0] idx,
                             input logic signed [COEF_BITS-1:0] val);
        send_item(cmd, SAMPLE_BITS'($urandom), idx, val);
    endtask

    // Drop valid, drain every expected result, then let the block settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Write the gain register; call only while idle
    task automatic set_gain(input logic [GAIN_BITS-1:0] g);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        gain_q816 = g;
    endtask

    function automatic logic signed [COEF_BITS-1:0] rand_coef();
        logic signed [COEF_BITS-1:0] c;
        case ($urandom_range(9))
            0: c = COEF_BITS'($urandom);
            1: c = CF_MAX;
            2: c = CF_MIN;
            3: c = '0;
            default: c = $signed(COEF_BITS'($urandom_range(0, 32'h0080_0000)))
                         - $signed(COEF_BITS'(32'h0040_0000));
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        logic signed [SAMPLE_BITS-1:0] s;
        case ($urandom_range(15))
            0: s = SMP_MAX;
            1: s = SMP_MIN;
            2: s = '0;
            default: s = SAMPLE_BITS'($urandom);
        endcase
        return s;
    endfunction

    // All stores are zero after reset, so every sample gives zero
    task automatic test_zero_coefs();
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
    endtask

    // Load first and last taps of both stores, feedback tap 1 and the unused feedback tap 0
    task automatic test_coef_loads();
        send_load(CMD_LOAD_FF, '0, CF_ONE);
        send_load(CMD_LOAD_FF, LAST_TAP, CF_MIN);
        send_load(CMD_LOAD_FB, '0, CF_MAX);
        send_load(CMD_LOAD_FB, IDX_BITS'(1), -(CF_ONE >>> 1));
        send_load(CMD_LOAD_FB, LAST_TAP, CF_ONE >>> 2);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample('0);
        send_sample(-SAMPLE_BITS'(1));
    endtask

    // Drive the feedback value into saturation both ways
    task automatic test_saturation();
        send_load(CMD_LOAD_FF, '0, CF_MAX);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
    endtask

    // Clear history, keep coefficients and the write slot
    task automatic test_clear();
        send_item(CMD_CLEAR, SMP_MIN, LAST_TAP, CF_MAX);
        send_load(CMD_LOAD_FF, '0, CF_ONE);
        send_sample(SAMPLE_BITS'(24'h40_0000));
    endtask

    // Gain at zero and at full scale
    task automatic test_gain_extremes();
        wait_idle();
        set_gain('0);
        send_sample(SMP_MAX);
        wait_idle();
        set_gain({GAIN_BITS{1'b1}});
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        wait_idle();
        set_gain(GAIN_RESET);
    endtask

    // Random mix of samples, loads and clears with a new gain every 150 items
    task automatic test_random(input int n, input int s_pct, input int r_pct);
        int i;
        int pick;
        snd_idle_pct = s_pct;
        rcv_idle_pct = r_pct;
        for (i = 0; i < n; i++) begin
            if (i % 150 == 0) begin
                wait_idle();
                case ($urandom_range(3))
                    0: set_gain(GAIN_RESET);
                    1: set_gain(GAIN_BITS'($urandom));
                    default: set_gain(GAIN_BITS'($urandom_range(0, 24'h03_0000)));
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 78)
                send_sample(rand_sample());
            else if (pick < 88)
                send_load(CMD_LOAD_FF, IDX_BITS'($urandom), rand_coef());
            else if (pick < 97)
                send_load(CMD_LOAD_FB, IDX_BITS'($urandom), rand_coef());
            else
                send_item(CMD_CLEAR, SAMPLE_BITS'($urandom), IDX_BITS'($urandom),
                          COEF_BITS'($urandom));
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < NTAPS; k++) begin
            x_hist[k]  = '0;
            y_hist[k]  = '0;
            ff_coef[k] = '0;
            fb_coef[k] = '0;
        end
        slot      = '0;
        gain_q816 = GAIN_RESET;
        snd_idle_pct = 20;
        rcv_idle_pct = 71;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_coefs();
        test_coef_loads();
        test_saturation();
        test_clear();
        test_gain_extremes();
        test_random(430, 20, 71);
        test_random(430, 71, 20);
        test_random(430, 0, 0);

        wait_idle();
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
